>>> hdl/rhls_pkg.sv
// shared types and constants for the rgb lightness and saturation block
package rhls_pkg;

   localparam int CHAN_W    = 8;
   localparam int NUM_CELLS = CHAN_W;        // one quotient bit per cell
   localparam int WORD_W    = 2 * CHAN_W;    // remainder and quotient word

   localparam logic [CHAN_W-1:0] SCALE        = 8'd255;
   localparam logic [CHAN_W-1:0] BRIGHT_LIMIT = 8'd128;
   localparam logic [CHAN_W:0]   BRIGHT_BASE  = 9'd511;

   // item travelling down the divider row
   typedef struct packed {
      logic [WORD_W-1:0] word;   // partial remainder above, numerator then quotient bits below
      logic [CHAN_W-1:0] dvs;
      logic [CHAN_W-1:0] light;
      logic              black;
   } rhls_cell_type;

endpackage

>>> hdl/rhls_front.sv
// front stage: channel min and max, lightness, divisor and scaled span
module rhls_front
   import rhls_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic [CHAN_W-1:0]    red,
   input  logic [CHAN_W-1:0]    green,
   input  logic [CHAN_W-1:0]    blue,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rhls_cell_type        dn_data
);

   logic [CHAN_W-1:0] hi_rg, lo_rg, hi, lo, span, light;
   logic [CHAN_W:0]   sum, bright_dvs;
   logic              valid_ff;
   rhls_cell_type     data_ff, data_in;

   always_comb begin
      hi_rg = (red > green) ? red : green;
      lo_rg = (red < green) ? red : green;
      hi    = (hi_rg > blue) ? hi_rg : blue;
      lo    = (lo_rg < blue) ? lo_rg : blue;
      sum   = {1'b0, hi} + {1'b0, lo};
      span  = hi - lo;
      light = sum[CHAN_W:1];
      bright_dvs = BRIGHT_BASE - sum;
      data_in.word  = WORD_W'(span * SCALE);
      // bright branch divisor is 1..255, dark branch is the sum itself
      data_in.dvs   = (light >= BRIGHT_LIMIT) ? bright_dvs[CHAN_W-1:0] : sum[CHAN_W-1:0];
      data_in.light = light;
      data_in.black = (sum == '0);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/rhls_div_cell.sv
// one restoring division step: yields one quotient bit per item
module rhls_div_cell
   import rhls_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  rhls_cell_type up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output rhls_cell_type dn_data
);

   logic [CHAN_W:0] trial, rest;
   logic            qbit, valid_ff;
   rhls_cell_type   data_ff, data_in;

   always_comb begin
      trial = up_data.word[WORD_W-1:CHAN_W-1];
      qbit  = (trial >= {1'b0, up_data.dvs});
      rest  = qbit ? (trial - {1'b0, up_data.dvs}) : trial;
      data_in = up_data;
      // remainder stays below the divisor, so its top bit is always clear
      data_in.word = {rest[CHAN_W-1:0], up_data.word[CHAN_W-2:0], qbit};
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/rgb_hsl_lightness_saturation_top.sv
// top level of the rgb to hsl lightness and saturation block
//
// usage
//   req channel: one rgb pixel per item (req_red, req_green, req_blue),
//   taken when req_valid and req_ready are both high
//   rsp channel: hsl lightness and saturation of that pixel, offered on
//   rsp_valid and taken when rsp_ready is high
//   pipeline: registered in the front stage (min, max, divisor, 255 times
//   span) and then in each of the 8 division cells
//   throughput: one item per clock cycle while rsp_ready stays high,
//   set by the row of division cells, each of which resolves one
//   quotient bit of every item
//   reset: synchronous and active high, empties every stage, no result
//   is offered in the cycle after it
//   stall: while rsp_ready is low the last cell holds its result; each
//   stage further up keeps accepting as long as the stage below it has
//   room, so req_ready only falls once the whole row is full
//   black pixels give saturation zero, gray pixels fall out as zero
module rgb_hsl_lightness_saturation_top
   import rhls_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAN_W-1:0] rsp_lightness,
   output logic [CHAN_W-1:0] rsp_chroma_saturation
);

   // stage k feeds cell k; stage NUM_CELLS is the output register
   logic          stage_valid [NUM_CELLS+1];
   logic          stage_ready [NUM_CELLS+1];
   rhls_cell_type stage_data  [NUM_CELLS+1];

   rhls_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .dn_valid (stage_valid[0]),
      .dn_ready (stage_ready[0]),
      .dn_data  (stage_data[0])
   );

   // row of identical division cells, most significant quotient bit first
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      rhls_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[k]),
         .up_ready (stage_ready[k]),
         .up_data  (stage_data[k]),
         .dn_valid (stage_valid[k+1]),
         .dn_ready (stage_ready[k+1]),
         .dn_data  (stage_data[k+1])
      );
   end

   assign stage_ready[NUM_CELLS] = rsp_ready;
   assign rsp_valid              = stage_valid[NUM_CELLS];
   assign rsp_lightness          = stage_data[NUM_CELLS].light;
   // divisor of a black pixel is zero, so its quotient bits mean nothing
   assign rsp_chroma_saturation  = stage_data[NUM_CELLS].black ? '0
                                 : stage_data[NUM_CELLS].word[CHAN_W-1:0];

endmodule

>>> hdl/rhls_checker.sv
// port level checks for the rgb lightness and saturation block
module rhls_checker
   import rhls_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [CHAN_W-1:0] req_red,
   input logic [CHAN_W-1:0] req_green,
   input logic [CHAN_W-1:0] req_blue,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_lightness,
   input logic [CHAN_W-1:0] rsp_chroma_saturation
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lightness)
                                 && $stable(rsp_chroma_saturation))
      else $error("stalled result changed or vanished");

   // an open receiver lets every stage move, so the input never blocks
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while receiver is ready");

   // reset empties the row
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind rgb_hsl_lightness_saturation_top rhls_checker u_rhls_checker (.*);
